// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file lr_checker.sv
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds in the following cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/lr_pkg.sv -----
// constants and codes for the line rasterizer
// no dependencies
package lr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SCREEN_BITS    = 11;
    localparam int ADDR_BITS      = 20;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 11'd200;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

// ----- hdl/line_rasterizer.sv -----
// line rasterizer top level: bresenham stepping, clipping and address generation
// depends on lr_pkg
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | opcode, start_x, start_y, end_x_in, end_y_in,
//          |           |                      | pen_color
//  out     | output    | out_valid / out_ready| write_enable, pixel_address, pixel_x, pixel_y,
//          |           |                      | pixel_color, last_pixel
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one request per cycle while in_ready is high; a step request's pixel is registered for out
// the address multiplier sits between the coordinate registers and the output register
// a two-entry output buffer lets one more request in while the output is stalled;
// in_ready drops only while both entries are full
// asynchronous active-low reset: idle, screen 320 x 200, no line active
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      end_x_in,
    input  logic signed [COORD_BITS-1:0]      end_y_in,
    input  logic [lr_pkg::COLOR_BITS-1:0]     pen_color,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              write_enable,
    output logic [lr_pkg::ADDR_BITS-1:0]      pixel_address,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic [lr_pkg::COLOR_BITS-1:0]     pixel_color,
    output logic                              last_pixel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lr_pkg::SCREEN_BITS-1:0]    cfg_data
);
    import lr_pkg::*;

    localparam int ERR_W  = COORD_BITS + 2;
    localparam int E2_W   = ERR_W + 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int EXT_W  = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;
    localparam int PROD_W = ((COORD_BITS + SCREEN_BITS + 1) > ADDR_BITS) ?
                            (COORD_BITS + SCREEN_BITS + 1) : ADDR_BITS;

    // configuration
    logic [SCREEN_BITS-1:0] width_reg, height_reg;

    // line state
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, end_x_reg, end_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next, end_x_next, end_y_next;
    logic [COORD_BITS-1:0]        delta_x_reg, delta_y_reg, delta_x_next, delta_y_next;
    logic                         step_x_neg_reg, step_y_neg_reg;
    logic                         step_x_neg_next, step_y_neg_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         active_reg, active_next;

    // output buffer
    logic                         out_valid_reg, skid_valid_reg;
    logic                         we_reg, last_reg, skid_we_reg, skid_last_reg;
    logic [ADDR_BITS-1:0]         addr_reg, skid_addr_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, skid_px_reg, skid_py_reg;
    logic [COLOR_BITS-1:0]        pcol_reg, skid_pcol_reg;

    logic                         accept, start_go, step_go;
    logic                         on_screen, at_end, move_x, move_y;
    logic [ADDR_BITS-1:0]         addr_calc;
    logic signed [EXT_W-1:0]      x_ext, y_ext, w_ext, h_ext;
    logic [PROD_W-1:0]            prod;
    logic signed [E2_W-1:0]       e2, dx_ext, dy_ext, err_sum;
    logic signed [DIFF_W-1:0]     diff_x, diff_y;

    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign start_go  = accept && (opcode == OP_START);
    assign step_go   = accept && (opcode == OP_STEP) && active_reg;

    // pixel result from current state
    assign x_ext  = EXT_W'(cur_x_reg);
    assign y_ext  = EXT_W'(cur_y_reg);
    assign w_ext  = $signed(EXT_W'(width_reg));
    assign h_ext  = $signed(EXT_W'(height_reg));
    assign on_screen = (x_ext >= 0) && (y_ext >= 0) && (x_ext < w_ext) && (y_ext < h_ext);
    assign at_end = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign prod   = PROD_W'($unsigned(cur_y_reg)) * PROD_W'(width_reg)
                    + PROD_W'($unsigned(cur_x_reg));
    assign addr_calc = on_screen ? prod[ADDR_BITS-1:0] : '0;

    // bresenham decisions
    assign e2     = {err_reg, 1'b0};
    assign dx_ext = $signed(E2_W'(delta_x_reg));
    assign dy_ext = $signed(E2_W'(delta_y_reg));
    assign move_x = e2 > -dy_ext;
    assign move_y = e2 < dx_ext;
    assign err_sum = E2_W'(err_reg) - (move_x ? dy_ext : E2_W'(0))
                     + (move_y ? dx_ext : E2_W'(0));

    // start setup
    assign diff_x = DIFF_W'(end_x_in) - DIFF_W'(start_x);
    assign diff_y = DIFF_W'(end_y_in) - DIFF_W'(start_y);

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        err_next        = err_reg;
        color_next      = color_reg;
        active_next     = active_reg;
        if (start_go)
        begin
            cur_x_next      = start_x;
            cur_y_next      = start_y;
            end_x_next      = end_x_in;
            end_y_next      = end_y_in;
            delta_x_next    = (diff_x < 0) ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
            delta_y_next    = (diff_y < 0) ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
            step_x_neg_next = !(diff_x > 0);
            step_y_neg_next = !(diff_y > 0);
            err_next        = $signed(ERR_W'(delta_x_next)) - $signed(ERR_W'(delta_y_next));
            color_next      = pen_color;
            active_next     = 1'b1;
        end
        else if (step_go)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = ERR_W'(err_sum);
                if (move_x)
                begin
                    cur_x_next = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                                : cur_x_reg + COORD_BITS'(1);
                end
                if (move_y)
                begin
                    cur_y_next = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                                : cur_y_reg + COORD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg        <= '0;
            color_reg      <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            err_reg        <= err_next;
            color_reg      <= color_next;
            active_reg     <= active_next;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (step_go)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= step_go;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (step_go)
            begin
                skid_we_reg   <= on_screen;
                skid_addr_reg <= addr_calc;
                skid_px_reg   <= cur_x_reg;
                skid_py_reg   <= cur_y_reg;
                skid_pcol_reg <= color_reg;
                skid_last_reg <= at_end;
            end
        end
        else if (skid_valid_reg)
        begin
            we_reg   <= skid_we_reg;
            addr_reg <= skid_addr_reg;
            px_reg   <= skid_px_reg;
            py_reg   <= skid_py_reg;
            pcol_reg <= skid_pcol_reg;
            last_reg <= skid_last_reg;
        end
        else if (step_go)
        begin
            we_reg   <= on_screen;
            addr_reg <= addr_calc;
            px_reg   <= cur_x_reg;
            py_reg   <= cur_y_reg;
            pcol_reg <= color_reg;
            last_reg <= at_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = we_reg;
    assign pixel_address = addr_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_color   = pcol_reg;
    assign last_pixel    = last_reg;

endmodule

// ----- hdl/lr_checker.sv -----
// port-level checks for the line rasterizer, bound to the top level
// depends on lr_pkg and assert_macros.svh
`include "assert_macros.svh"

module lr_checker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              write_enable,
    input logic [lr_pkg::ADDR_BITS-1:0]      pixel_address,
    input logic signed [COORD_BITS-1:0]      pixel_x,
    input logic signed [COORD_BITS-1:0]      pixel_y
);
    import lr_pkg::*;

    // stalled result keeps its address
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_address))
    // input backpressure only when a result is waiting
    `ASSERT_SAME(a_ready_low, !in_ready, out_valid)
    // written pixels are never at negative coordinates
    `ASSERT_SAME(a_we_nonneg, out_valid && write_enable,
                 !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
    // clipped pixel carries a zero address
    `ASSERT_SAME(a_clip_addr, out_valid && !write_enable, pixel_address == '0)

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);
